// File: rtl/core/vrsd_pkg.sv
// Shared types, constants and helpers of the run-length voxel slice decoder.
// No dependencies.
`default_nettype none

package vrsd_pkg;

  localparam int MAX_DIM = 256;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int POS_W = 8;
  localparam int IDX_W = 16;
  localparam int LEN_W = 17;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] CODEFLAG = 32'd2;
  localparam logic [WORD_W-1:0] NEXTSLICEFLAG = 32'd6;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = 1;
  localparam int Q_CW = 2;

  localparam int DIV_STEPS = IDX_W / 2;
  localparam int DIV_CW = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_COMPRESSED = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_WORD = 2'd0,
    PH_COUNT = 2'd1,
    PH_COLOR = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV = 2'd1,
    B_HOLD = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [8:0] size_x;
    logic [8:0] size_y;
    logic [8:0] size_z;
    logic compressed;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] z;
    logic [LEN_W-1:0] len;
    logic [WORD_W-1:0] color;
    logic done;
    logic ovf;
  } cmd_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [8:0] v);
    logic [DIM_W-1:0] r;
    if (v == 9'd0) begin
      r = DIM_W'(1);
    end else if ({1'b0, v} > 10'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vrsd_front.sv
// Front end: accepts payload words, tracks phase and slice position,
// and issues fill commands to the queue. Depends on vrsd_pkg.
`default_nettype none

module vrsd_front (
  input wire logic clk,
  input wire logic rst,
  input wire vrsd_pkg::cfg_t cfg,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [31:0] word,
  input wire logic q_full,
  output logic push,
  output vrsd_pkg::cmd_t cmd
);

  vrsd_pkg::phase_t phase, phase_next;
  logic [vrsd_pkg::LEN_W-1:0] pending, pending_next;
  logic [vrsd_pkg::LEN_W-1:0] slice_index, slice_index_next;
  logic [vrsd_pkg::POS_W-1:0] slice_z, slice_z_next;

  logic [vrsd_pkg::DIM_W-1:0] sx, sy, sz;
  logic [vrsd_pkg::LEN_W-1:0] ss, si_raw, idx1, avail, len_c;
  logic [vrsd_pkg::POS_W:0] zp1;
  logic z_last, emit, accept;

  assign sx = vrsd_pkg::eff_dim(cfg.size_x);
  assign sy = vrsd_pkg::eff_dim(cfg.size_y);
  assign sz = vrsd_pkg::eff_dim(cfg.size_z);
  assign ss = vrsd_pkg::LEN_W'(sx) * vrsd_pkg::LEN_W'(sy);
  assign zp1 = {1'b0, slice_z} + 9'd1;
  assign z_last = (vrsd_pkg::DIM_W'(zp1) >= sz);
  assign si_raw = (slice_index >= ss) ? '0 : slice_index;
  assign idx1 = si_raw + vrsd_pkg::LEN_W'(1);
  assign avail = ss - slice_index;
  assign len_c = (pending > avail) ? avail : pending;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && emit;

  always_comb begin
    phase_next = vrsd_pkg::PH_WORD;
    if (cfg.compressed) begin
      case (phase)
        vrsd_pkg::PH_COUNT: phase_next = vrsd_pkg::PH_COLOR;
        vrsd_pkg::PH_COLOR: phase_next = vrsd_pkg::PH_WORD;
        default: begin
          if (word == vrsd_pkg::CODEFLAG) begin
            phase_next = vrsd_pkg::PH_COUNT;
          end
        end
      endcase
    end
  end

  always_comb begin
    emit = 1'b0;
    cmd.idx = slice_index[vrsd_pkg::IDX_W-1:0];
    cmd.z = slice_z;
    cmd.len = vrsd_pkg::LEN_W'(1);
    cmd.color = word;
    cmd.done = 1'b0;
    cmd.ovf = 1'b0;
    pending_next = pending;
    slice_index_next = slice_index;
    slice_z_next = slice_z;
    if (!cfg.compressed) begin
      emit = 1'b1;
      pending_next = '0;
      cmd.idx = si_raw[vrsd_pkg::IDX_W-1:0];
      cmd.done = (idx1 >= ss) && z_last;
      if (cmd.done) begin
        slice_index_next = '0;
        slice_z_next = '0;
      end else if (idx1 >= ss) begin
        slice_index_next = '0;
        slice_z_next = zp1[vrsd_pkg::POS_W-1:0];
      end else begin
        slice_index_next = idx1;
      end
    end else begin
      case (phase)
        vrsd_pkg::PH_COUNT: begin
          pending_next = ({15'd0, ss} < word) ? ss : word[vrsd_pkg::LEN_W-1:0];
        end
        vrsd_pkg::PH_COLOR: begin
          pending_next = '0;
          if (pending != '0 && slice_index < ss) begin
            emit = 1'b1;
            cmd.len = len_c;
            cmd.ovf = (pending > avail);
            slice_index_next = slice_index + len_c;
          end
        end
        default: begin
          if (word == vrsd_pkg::NEXTSLICEFLAG) begin
            slice_index_next = '0;
            if (z_last) begin
              emit = 1'b1;
              pending_next = '0;
              slice_z_next = '0;
              cmd.idx = '0;
              cmd.z = '0;
              cmd.len = '0;
              cmd.color = '0;
              cmd.done = 1'b1;
            end else begin
              slice_z_next = zp1[vrsd_pkg::POS_W-1:0];
            end
          end else if (word != vrsd_pkg::CODEFLAG && slice_index < ss) begin
            emit = 1'b1;
            slice_index_next = idx1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= vrsd_pkg::PH_WORD;
      pending <= '0;
      slice_index <= '0;
      slice_z <= '0;
    end else if (accept) begin
      phase <= phase_next;
      pending <= pending_next;
      slice_index <= slice_index_next;
      slice_z <= slice_z_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vrsd_queue.sv
// Short command queue between front and back end.
// Depends on vrsd_pkg.
`default_nettype none

module vrsd_queue (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire vrsd_pkg::cmd_t wdata,
  input wire logic pop,
  output vrsd_pkg::cmd_t rdata,
  output logic full,
  output logic empty
);

  vrsd_pkg::cmd_t mem [vrsd_pkg::Q_DEPTH];
  logic [vrsd_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [vrsd_pkg::Q_CW-1:0] count;

  assign full = (count == vrsd_pkg::Q_CW'(vrsd_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + vrsd_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + vrsd_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + vrsd_pkg::Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - vrsd_pkg::Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vrsd_back.sv
// Back end: splits the slice index into x and y with a two-bit-per-cycle
// divider and drives the result register. Depends on vrsd_pkg.
`default_nettype none

module vrsd_back (
  input wire logic clk,
  input wire logic rst,
  input wire vrsd_pkg::cfg_t cfg,
  input wire logic q_empty,
  input wire vrsd_pkg::cmd_t q_data,
  output logic pop,
  output logic out_valid,
  input wire logic out_ready,
  output logic [7:0] pos_x,
  output logic [7:0] pos_y,
  output logic [7:0] pos_z,
  output logic [16:0] run_length,
  output logic [31:0] color,
  output logic matrix_done,
  output logic overflow
);

  vrsd_pkg::back_state_t state, state_next;
  vrsd_pkg::cmd_t job;
  logic [vrsd_pkg::IDX_W-1:0] quo;
  logic [7:0] rem;
  logic [vrsd_pkg::DIV_CW-1:0] cnt;
  logic [vrsd_pkg::DIM_W-1:0] sx;
  logic [8:0] step1, step2;
  logic load, out_free;

  function automatic logic [8:0] div_step(input logic [7:0] r_in, input logic b,
                                          input logic [vrsd_pkg::DIM_W-1:0] d);
    logic [8:0] r;
    logic [8:0] res;
    r = {r_in, b};
    if (r >= 9'(d)) begin
      r = r - 9'(d);
      res = {1'b1, r[7:0]};
    end else begin
      res = {1'b0, r[7:0]};
    end
    return res;
  endfunction

  assign sx = vrsd_pkg::eff_dim(cfg.size_x);
  assign step1 = div_step(rem, quo[vrsd_pkg::IDX_W-1], sx);
  assign step2 = div_step(step1[7:0], quo[vrsd_pkg::IDX_W-2], sx);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      vrsd_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = vrsd_pkg::B_DIV;
        end
      end
      vrsd_pkg::B_DIV: begin
        if (cnt == vrsd_pkg::DIV_CW'(vrsd_pkg::DIV_STEPS - 1)) begin
          state_next = vrsd_pkg::B_HOLD;
        end
      end
      vrsd_pkg::B_HOLD: begin
        if (out_free) begin
          state_next = vrsd_pkg::B_IDLE;
        end
      end
      default: state_next = vrsd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == vrsd_pkg::B_IDLE) && !q_empty;
    load = (state == vrsd_pkg::B_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrsd_pkg::B_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        cnt <= '0;
      end else if (state == vrsd_pkg::B_DIV) begin
        cnt <= cnt + vrsd_pkg::DIV_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_data;
      quo <= q_data.idx;
      rem <= '0;
    end else if (state == vrsd_pkg::B_DIV) begin
      quo <= {quo[vrsd_pkg::IDX_W-3:0], step1[8], step2[8]};
      rem <= step2[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_x <= rem;
      pos_y <= quo[7:0];
      pos_z <= job.z;
      run_length <= job.len;
      color <= job.color;
      matrix_done <= job.done;
      overflow <= job.ovf;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == vrsd_pkg::B_IDLE)
    else $error("pop outside idle");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == vrsd_pkg::B_DIV && cnt == vrsd_pkg::DIV_CW'(vrsd_pkg::DIV_STEPS - 1))
    |=> state == vrsd_pkg::B_HOLD)
    else $error("divider did not finish");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == vrsd_pkg::B_HOLD |-> {1'b0, rem} < 9'(sx))
    else $error("remainder not below width");

endmodule

`default_nettype wire

// File: rtl/core/voxel_rle_slice_decoder.sv
// A producing word passes the queue to the idle back end; its 2-bit-per-cycle x/y divider runs
// in B_DIV, the result is loaded from B_HOLD, and only then is the next command popped. Words
// that give no result transfer one per cycle while the 2-entry queue has room.
// Reset: sizes 1, compressed mode, phase/count/slice index/slice z cleared, queue and output empty.
// Holds the configuration registers and joins front end, queue and back end.
`default_nettype none

module voxel_rle_slice_decoder (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_write,
  input wire logic [1:0] cfg_index,
  input wire logic [8:0] cfg_data,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [31:0] word,
  output logic out_valid,
  input wire logic out_ready,
  output logic [7:0] pos_x,
  output logic [7:0] pos_y,
  output logic [7:0] pos_z,
  output logic [16:0] run_length,
  output logic [31:0] color,
  output logic matrix_done,
  output logic overflow
);

  vrsd_pkg::cfg_t cfg;
  vrsd_pkg::cmd_t f_cmd, q_cmd;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x <= 9'd1;
      cfg.size_y <= 9'd1;
      cfg.size_z <= 9'd1;
      cfg.compressed <= 1'b1;
    end else if (cfg_write) begin
      case (vrsd_pkg::reg_idx_t'(cfg_index))
        vrsd_pkg::REG_SIZE_X: cfg.size_x <= cfg_data;
        vrsd_pkg::REG_SIZE_Y: cfg.size_y <= cfg_data;
        vrsd_pkg::REG_SIZE_Z: cfg.size_z <= cfg_data;
        vrsd_pkg::REG_COMPRESSED: cfg.compressed <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  vrsd_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .word(word),
    .q_full(q_full),
    .push(push),
    .cmd(f_cmd)
  );

  vrsd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(f_cmd),
    .pop(pop),
    .rdata(q_cmd),
    .full(q_full),
    .empty(q_empty)
  );

  vrsd_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_empty(q_empty),
    .q_data(q_cmd),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .run_length(run_length),
    .color(color),
    .matrix_done(matrix_done),
    .overflow(overflow)
  );

endmodule

`default_nettype wire
